/* rtl/color_tag_parser_macros.svh */
// ----------------------------------------------------------------------------
// color_tag_parser_macros
// Assertion helpers used by the color tag parser RTL.
// ----------------------------------------------------------------------------
`ifndef COLOR_TAG_PARSER_MACROS_SVH
`define COLOR_TAG_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Types, codes and the color name table of the color tag parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

	// Parameter defaults
	localparam int MAX_TAG_DEF      = 20;
	localparam int NAME_ENTRIES_DEF = 26;

	// Entries present in the name table
	localparam int ROM_SIZE = 26;

	// Characters of interest
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_UC   = 8'h43;
	localparam logic [7:0] CH_LC   = 8'h63;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Largest legal palette index, and the saturation value above it
	localparam logic [8:0] INDEX_MAX = 9'd255;
	localparam logic [8:0] INDEX_SAT = 9'd256;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_OPEN  = 3'd1;
	localparam logic [2:0] ST_ENDED    = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_BAD_IDX  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;

	// Parser phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	// One input beat
	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} item_t;

	// One result beat
	typedef struct packed {
		logic       found;
		logic [7:0] color;
		logic [4:0] tag_length;
		logic [2:0] status;
	} result_t;

	// Name table: text right-justified, last character in the low byte
	localparam logic [63:0] NAME_TXT [ROM_SIZE] = '{
		64'("WHITE"),   64'("BLACK"),   64'("GOLD"),    64'("SILVER"),
		64'("SLATE"),   64'("PINK"),    64'("MAROON"),  64'("BROWN"),
		64'("TAN"),     64'("SAND"),    64'("CREAM"),   64'("RUST"),
		64'("LIME"),    64'("OLIVE"),   64'("FOREST"),  64'("MINT"),
		64'("SEABLUE"), 64'("SKYBLUE"), 64'("NAVY"),    64'("PLUM"),
		64'("GRAY"),    64'("VIOLET"),  64'("CRIMSON"), 64'("SEAGREEN"),
		64'("TEAL"),    64'("CYAN")
	};

	localparam logic [3:0] NAME_LEN [ROM_SIZE] = '{
		4'd5, 4'd5, 4'd4, 4'd6, 4'd5, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4,
		4'd5, 4'd4, 4'd4, 4'd5, 4'd6, 4'd4, 4'd7, 4'd7, 4'd4, 4'd4,
		4'd4, 4'd6, 4'd7, 4'd8, 4'd4, 4'd4
	};

	localparam logic [7:0] NAME_COLOR [ROM_SIZE] = '{
		8'd7,   8'd0,   8'd244, 8'd6,   8'd11,  8'd118, 8'd30,  8'd15,
		8'd104, 8'd47,  8'd140, 8'd46,  8'd238, 8'd158, 8'd179, 8'd103,
		8'd132, 8'd22,  8'd16,  8'd113, 8'd6,   8'd129, 8'd254, 8'd207,
		8'd251, 8'd251
	};

	// Character of entry idx at position pos (pos below the entry's length)
	function automatic logic [7:0] name_char(input int unsigned idx, input logic [2:0] pos);
		logic [63:0] txt;
		logic [3:0]  len;
		logic [2:0]  sel;
		txt = NAME_TXT[idx];
		len = NAME_LEN[idx];
		sel = 3'(len - {1'b0, pos} - 4'd1);
		return txt[{sel, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

/* rtl/color_tag_parser.sv */
// ----------------------------------------------------------------------------
// color_tag_parser
// Recognizes a leading <NAME> or <Cddd> color tag in a character stream.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one character per beat (item.ch) with item.start_req set on
//   the first character of each string; a start abandons any open string.
//   result channel: at most one beat per string, sent when the tag is
//   decided (found, color, tag_length, status).
//   Path: an input beat is registered in the input register, then decoded into
//   the result register. Throughput: one character per cycle while item_stall
//   is low; name matching and the decimal accumulator update in parallel in a
//   single stage.
//   Reset: the parser is idle; characters are ignored until a start.
//   Stall: while result_stall holds a waiting result, the input register
//   keeps taking characters that decide nothing; a character that would
//   produce a result waits there and item_stall rises until the result
//   register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_tag_parser_macros.svh"

module color_tag_parser #(
	parameter int MAX_TAG      = ctp_pkg::MAX_TAG_DEF,
	parameter int NAME_ENTRIES = ctp_pkg::NAME_ENTRIES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire ctp_pkg::item_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output ctp_pkg::result_t     result
);

	localparam int CW = $clog2(MAX_TAG);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TAG - 1);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	// Input stage
	ctp_pkg::item_t item_s1;
	logic           valid_s1;

	// Parser state
	ctp_pkg::phase_t         phase_q, phase_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic                    index_form_q, index_form_d;
	logic                    digit_seen_q, digit_seen_d;
	logic [8:0]              index_q, index_d;
	logic [NAME_ENTRIES-1:0] match_q, match_d;

	// Result register
	ctp_pkg::result_t result_s2, res_d;

	logic              emit;
	logic              adv;
	logic              is_start, is_lt, is_nul, is_gt, is_digit, is_prefix, collecting;
	logic [CW-1:0]     pos;
	logic [12:0]       acc_sum;
	logic [NAME_ENTRIES-1:0] keep;
	logic [NAME_ENTRIES-1:0] hit;
	logic [7:0]        ent_color [NAME_ENTRIES];
	logic              name_hit;
	logic [7:0]        name_color;

	// Decode the registered character
	assign is_start   = item_s1.start_req;
	assign is_lt      = (item_s1.ch == ctp_pkg::CH_LT);
	assign is_nul     = (item_s1.ch == ctp_pkg::CH_NUL);
	assign is_gt      = (item_s1.ch == ctp_pkg::CH_GT);
	assign is_digit   = (item_s1.ch >= ctp_pkg::CH_ZERO) && (item_s1.ch <= ctp_pkg::CH_NINE);
	assign is_prefix  = (item_s1.ch == ctp_pkg::CH_UC) || (item_s1.ch == ctp_pkg::CH_LC);
	assign collecting = (phase_q == ctp_pkg::PH_COLLECT);
	assign pos        = cnt_q - CNT_ONE;

	// Beat decides a tag
	assign emit = valid_s1 && (is_start ? !is_lt : (collecting && (is_nul || is_gt)));

	// Advance the input stage unless its result would overwrite a waiting one
	assign adv        = valid_s1 && (!emit || !result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;

	// Accumulate one decimal digit: value * 10 + digit
	assign acc_sum = {1'b0, index_q, 3'b000} + {3'b000, index_q, 1'b0}
		+ {5'd0, item_s1.ch - ctp_pkg::CH_ZERO};

	// Per-entry character compare and length match
	for (genvar i = 0; i < NAME_ENTRIES; i++) begin : g_ent
		if (i < ctp_pkg::ROM_SIZE) begin : g_rom
			assign keep[i] = (6'(pos) < 6'(ctp_pkg::NAME_LEN[i]))
				&& (item_s1.ch == ctp_pkg::name_char(i, 3'(pos)));
			assign hit[i] = match_q[i] && (cnt_q >= CW'(2))
				&& (6'(pos) == 6'(ctp_pkg::NAME_LEN[i]));
			assign ent_color[i] = ctp_pkg::NAME_COLOR[i];
		end else begin : g_none
			assign keep[i]      = 1'b0;
			assign hit[i]       = 1'b0;
			assign ent_color[i] = 8'd0;
		end
	end

	// Pick the lowest-numbered matching entry
	always_comb begin
		name_hit   = 1'b0;
		name_color = 8'd0;
		for (int i = NAME_ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				name_hit   = 1'b1;
				name_color = ent_color[i];
			end
		end
	end

	// Next state
	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		index_form_d = index_form_q;
		digit_seen_d = digit_seen_q;
		index_d      = index_q;
		match_d      = match_q;
		if (is_start) begin
			if (is_lt) begin
				phase_d      = ctp_pkg::PH_COLLECT;
				cnt_d        = CNT_ONE;
				index_form_d = 1'b1;
				digit_seen_d = 1'b0;
				index_d      = 9'd0;
				match_d      = '1;
			end else begin
				phase_d = ctp_pkg::PH_DONE;
			end
		end else if (collecting) begin
			if (is_nul || is_gt) begin
				phase_d = ctp_pkg::PH_DONE;
			end else begin
				if (pos == '0) begin
					index_form_d = is_prefix;
				end else if (is_digit) begin
					index_d      = (acc_sum > 13'(ctp_pkg::INDEX_SAT))
						? ctp_pkg::INDEX_SAT : acc_sum[8:0];
					digit_seen_d = 1'b1;
				end else begin
					index_form_d = 1'b0;
				end
				match_d = match_q & keep;
				if (cnt_q < CNT_MAX) begin
					cnt_d = cnt_q + CNT_ONE;
				end
			end
		end
	end

	// Result of a deciding beat
	always_comb begin
		res_d = '0;
		if (is_start || is_nul) begin
			res_d.status = is_start ? ctp_pkg::ST_NO_OPEN : ctp_pkg::ST_ENDED;
		end else if (cnt_q >= CNT_MAX) begin
			res_d.status = ctp_pkg::ST_TOO_LONG;
		end else if ((cnt_q >= CW'(2)) && index_form_q) begin
			if (!digit_seen_q || (index_q > ctp_pkg::INDEX_MAX)) begin
				res_d.status = ctp_pkg::ST_BAD_IDX;
			end else begin
				res_d.found      = 1'b1;
				res_d.color      = index_q[7:0];
				res_d.tag_length = 5'({1'b0, cnt_q} + {1'b0, CNT_ONE});
				res_d.status     = ctp_pkg::ST_OK;
			end
		end else if (name_hit) begin
			res_d.found      = 1'b1;
			res_d.color      = name_color;
			res_d.tag_length = 5'({1'b0, cnt_q} + {1'b0, CNT_ONE});
			res_d.status     = ctp_pkg::ST_OK;
		end else begin
			res_d.status = ctp_pkg::ST_UNKNOWN;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ctp_pkg::PH_IDLE;
			cnt_q        <= '0;
			index_form_q <= 1'b1;
			digit_seen_q <= 1'b0;
			index_q      <= 9'd0;
			match_q      <= '1;
		end else if (adv) begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			index_form_q <= index_form_d;
			digit_seen_q <= digit_seen_d;
			index_q      <= index_d;
			match_q      <= match_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && emit) begin
			result_valid <= 1'b1;
		end else if (result_valid && !result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			result_s2 <= res_d;
		end
	end

	assign result = result_s2;

	// Checks
	`CTP_ASSERT_NOW(a_found_ok, clk, arst_n, result_valid && result.found,
		(result.status == ctp_pkg::ST_OK) && (result.tag_length >= 5'd3),
		"found result without ok status or with short tag")
	`CTP_ASSERT_NOW(a_miss_clean, clk, arst_n, result_valid && !result.found,
		(result.color == 8'd0) && (result.tag_length == 5'd0)
		&& (result.status != ctp_pkg::ST_OK),
		"error result carries color, length or ok status")
	`CTP_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_MAX,
		"character count beyond saturation")
	`CTP_ASSERT_NEXT(a_emit_done, clk, arst_n, adv && emit,
		result_valid && (phase_q == ctp_pkg::PH_DONE),
		"decided tag left no result or parser not done")

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for color_tag_parser: a directed set of tags, then random strings
// built from palette names, index tags and noise. A scoreboard class predicts
// the verdict of each string and checks every result beat field by field.
// The item channel idles and the result channel stalls in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAG_LIMIT   = ctp_pkg::MAX_TAG_DEF;
	localparam int CHAR_TARGET = 1450;
	localparam int CALM_TAIL   = 200;
	localparam int HANG_LIMIT  = 1000;

	// Tracks the parser and holds the verdicts still to come out
	class tag_checker;
		ctp_pkg::phase_t  phase;
		logic [4:0]       count;
		bit               index_form;
		bit               digit_seen;
		logic [8:0]       index_value;
		logic [25:0]      alive;
		ctp_pkg::result_t verdicts[$];
		int               errors;
		int               live_chars;
		int               decided[8];
		string            names[26];
		logic [7:0]       colors[26];

		function new();
			names = '{"WHITE", "BLACK", "GOLD", "SILVER", "SLATE", "PINK", "MAROON",
				"BROWN", "TAN", "SAND", "CREAM", "RUST", "LIME", "OLIVE", "FOREST",
				"MINT", "SEABLUE", "SKYBLUE", "NAVY", "PLUM", "GRAY", "VIOLET",
				"CRIMSON", "SEAGREEN", "TEAL", "CYAN"};
			colors = '{8'd7, 8'd0, 8'd244, 8'd6, 8'd11, 8'd118, 8'd30, 8'd15,
				8'd104, 8'd47, 8'd140, 8'd46, 8'd238, 8'd158, 8'd179, 8'd103,
				8'd132, 8'd22, 8'd16, 8'd113, 8'd6, 8'd129, 8'd254, 8'd207,
				8'd251, 8'd251};
			phase = ctp_pkg::PH_IDLE;
			count = '0;
			index_form = 1'b1;
			digit_seen = 1'b0;
			index_value = '0;
			alive = '1;
		endfunction

		// Queue one verdict and close the string
		function void decide(logic ok, logic [7:0] col, logic [4:0] len, logic [2:0] st);
			ctp_pkg::result_t r;
			r.found = ok;
			r.color = col;
			r.tag_length = len;
			r.status = st;
			verdicts.push_back(r);
			decided[st]++;
			phase = ctp_pkg::PH_DONE;
		endfunction

		// Decide the tag at its closing bracket
		function void close_tag();
			int len;
			int nlen;
			len = count + 1;
			nlen = count - 1;
			if (len >= TAG_LIMIT) begin
				decide(1'b0, 8'd0, 5'd0, ctp_pkg::ST_TOO_LONG);
				return;
			end
			if (nlen >= 1 && index_form) begin
				if (!digit_seen || index_value > ctp_pkg::INDEX_MAX)
					decide(1'b0, 8'd0, 5'd0, ctp_pkg::ST_BAD_IDX);
				else
					decide(1'b1, index_value[7:0], 5'(len), ctp_pkg::ST_OK);
				return;
			end
			for (int i = 0; i < 26; i++) begin
				if (alive[i] && nlen >= 1 && names[i].len() == nlen) begin
					decide(1'b1, colors[i], 5'(len), ctp_pkg::ST_OK);
					return;
				end
			end
			decide(1'b0, 8'd0, 5'd0, ctp_pkg::ST_UNKNOWN);
		endfunction

		// Advance the parser by one accepted input beat
		function void take_char(ctp_pkg::item_t b);
			int pos;
			int v;
			if (b.start_req) begin
				live_chars++;
				if (b.ch != ctp_pkg::CH_LT) begin
					decide(1'b0, 8'd0, 5'd0, ctp_pkg::ST_NO_OPEN);
				end else begin
					phase = ctp_pkg::PH_COLLECT;
					count = 5'd1;
					index_form = 1'b1;
					digit_seen = 1'b0;
					index_value = '0;
					alive = '1;
				end
				return;
			end
			if (phase != ctp_pkg::PH_COLLECT)
				return;
			live_chars++;
			if (b.ch == ctp_pkg::CH_NUL) begin
				decide(1'b0, 8'd0, 5'd0, ctp_pkg::ST_ENDED);
				return;
			end
			if (b.ch == ctp_pkg::CH_GT) begin
				close_tag();
				return;
			end
			pos = count - 1;
			if (pos == 0) begin
				index_form = (b.ch == ctp_pkg::CH_UC || b.ch == ctp_pkg::CH_LC);
			end else if (b.ch >= ctp_pkg::CH_ZERO && b.ch <= ctp_pkg::CH_NINE) begin
				v = index_value * 10 + (b.ch - ctp_pkg::CH_ZERO);
				index_value = (v > ctp_pkg::INDEX_SAT) ? ctp_pkg::INDEX_SAT : v[8:0];
				digit_seen = 1'b1;
			end else begin
				index_form = 1'b0;
			end
			for (int i = 0; i < 26; i++) begin
				if (pos >= names[i].len() || names[i][pos] != b.ch)
					alive[i] = 1'b0;
			end
			if (count < TAG_LIMIT - 1)
				count++;
		endfunction

		// Compare a result beat with the oldest verdict
		function void check_verdict(ctp_pkg::result_t got);
			ctp_pkg::result_t want;
			if (verdicts.size() == 0) begin
				errors++;
				$error("result beat with no verdict pending: %p", got);
				return;
			end
			want = verdicts.pop_front();
			if (got.found !== want.found) begin
				errors++;
				$error("found: expected %0d, got %0d", want.found, got.found);
			end
			if (got.color !== want.color) begin
				errors++;
				$error("color: expected %0d, got %0d", want.color, got.color);
			end
			if (got.tag_length !== want.tag_length) begin
				errors++;
				$error("tag_length: expected %0d, got %0d", want.tag_length, got.tag_length);
			end
			if (got.status !== want.status) begin
				errors++;
				$error("status: expected %0d, got %0d", want.status, got.status);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	ctp_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	ctp_pkg::result_t result;

	tag_checker chk = new();
	logic [7:0] str[$];
	bit         calm;
	int         hang_cycles;

	color_tag_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Note accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				chk.take_char(item);
			if (result_valid && !result_stall)
				chk.check_verdict(result);
		end
	end

	// Give up when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			hang_cycles <= 0;
		end else if (hang_cycles >= HANG_LIMIT) begin
			$display("color_tag_parser test failed");
			$finish;
		end else begin
			hang_cycles <= hang_cycles + 1;
		end
	end

	// Stall the result channel in random bursts
	initial begin
		int hold;
		hold = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (!calm && $urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 18);
			result_stall = (hold > 0);
		end
	end

	// Offer one beat, after an occasional idle burst, and hold it until taken
	task automatic send_beat(input logic [7:0] c, input logic first);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 18);
			item_valid = 1'b0;
			item = ctp_pkg::item_t'(9'($urandom));
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		item.ch = c;
		item.start_req = first;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_str(input bit with_start);
		foreach (str[k])
			send_beat(str[k], with_start && k == 0);
	endtask

	task automatic load_text(input string s);
		str.delete();
		for (int k = 0; k < s.len(); k++)
			str.push_back(s[k]);
	endtask

	// Letters and digits, or any nonzero character when wide
	function automatic logic [7:0] filler(input bit wide);
		case ($urandom_range(0, 3))
			0: return "A" + 8'($urandom_range(0, 25));
			1: return "a" + 8'($urandom_range(0, 25));
			2: return ctp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			default: return wide ? 8'($urandom_range(1, 255)) : "Z";
		endcase
	endfunction

	// Build one random string into str
	task automatic compose_string();
		int    pick;
		int    n;
		int    at;
		bit    shut;
		string txt;
		str.delete();
		str.push_back(ctp_pkg::CH_LT);
		shut = 1'b1;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			// palette name, sometimes damaged or stretched
			txt = chk.names[$urandom_range(0, 25)];
			for (int k = 0; k < txt.len(); k++)
				str.push_back(txt[k]);
			if ($urandom_range(0, 3) == 0) begin
				at = $urandom_range(1, str.size() - 1);
				str[at] = $urandom_range(0, 1) ? (str[at] ^ 8'h20) : filler(1'b1);
			end else if ($urandom_range(0, 7) == 0) begin
				str.push_back(filler(1'b0));
			end
		end else if (pick < 62) begin
			// palette index, in range or random digits, sometimes mixed
			str.push_back($urandom_range(0, 1) ? ctp_pkg::CH_UC : ctp_pkg::CH_LC);
			if ($urandom_range(0, 1)) begin
				txt = $sformatf("%0d", $urandom_range(0, 255));
				for (int k = 0; k < txt.len(); k++)
					str.push_back(txt[k]);
			end else begin
				n = $urandom_range(0, 6);
				repeat (n) str.push_back(ctp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if (str.size() > 2 && $urandom_range(0, 4) == 0)
				str[$urandom_range(2, str.size() - 1)] = filler(1'b1);
		end else if (pick < 72) begin
			// near or over the length limit
			n = $urandom_range(14, 24);
			repeat (n) str.push_back(filler(1'b0));
		end else if (pick < 80) begin
			// empty forms, or a string that ends inside the tag
			case ($urandom_range(0, 2))
				0: ;
				1: str.push_back($urandom_range(0, 1) ? ctp_pkg::CH_UC : ctp_pkg::CH_LC);
				default: begin
					n = $urandom_range(0, 21);
					repeat (n) str.push_back(filler(1'b0));
					str.push_back(ctp_pkg::CH_NUL);
					shut = 1'b0;
				end
			endcase
		end else if (pick < 88) begin
			// no opening bracket, then ignored tail
			str[0] = 8'($urandom_range(0, 255));
			n = $urandom_range(0, 3);
			repeat (n) str.push_back(8'($urandom_range(0, 255)));
			shut = 1'b0;
		end else begin
			// arbitrary bytes inside the tag
			n = $urandom_range(0, 8);
			repeat (n) str.push_back(8'($urandom_range(0, 255)));
		end
		if (shut)
			str.push_back(ctp_pkg::CH_GT);
		// drop the tail now and then so the next start abandons the tag
		if (str.size() > 1 && $urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, str.size() - 1);
			while (str.size() > n)
				void'(str.pop_back());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		calm = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: ignored char, start on NUL and 0xFF, empty and edge tags
		str = '{8'h41};
		send_str(1'b0);
		str = '{ctp_pkg::CH_NUL};
		send_str(1'b1);
		str = '{8'hFF};
		send_str(1'b1);
		load_text("<>");
		send_str(1'b1);
		load_text("<C>");
		send_str(1'b1);
		load_text("<c255>");
		send_str(1'b1);
		load_text("<C256>");
		send_str(1'b1);
		load_text("<c7Z>");
		send_str(1'b1);
		str = '{ctp_pkg::CH_LT, ctp_pkg::CH_NUL};
		send_str(1'b1);

		// random strings with occasional stray beats between them
		while (chk.live_chars < CHAR_TARGET) begin
			calm = (chk.live_chars > CHAR_TARGET - CALM_TAIL);
			compose_string();
			send_str(1'b1);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		@(negedge clk);
		item_valid = 1'b0;

		// drain, then watch a little longer for stray results
		while (chk.verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d characters parsed; verdicts ok %0d, no bracket %0d, ended %0d,",
			chk.live_chars, chk.decided[ctp_pkg::ST_OK], chk.decided[ctp_pkg::ST_NO_OPEN],
			chk.decided[ctp_pkg::ST_ENDED]);
		$display("too long %0d, bad index %0d, unknown name %0d",
			chk.decided[ctp_pkg::ST_TOO_LONG], chk.decided[ctp_pkg::ST_BAD_IDX],
			chk.decided[ctp_pkg::ST_UNKNOWN]);
		if (chk.errors == 0) begin
			$display("color_tag_parser test passed");
		end else begin
			$display("color_tag_parser test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
